[src/pet_pkg.sv]
// Package for the pose error and path length tracker.
// Widths, item structs, sequencer states and unit response types.
// No dependencies.
package pet_pkg;

	localparam int COORD_BITS = 24;
	localparam int PATH_BITS  = 40;
	localparam int MAG_W      = COORD_BITS + 1;
	localparam int ROOT_W     = MAG_W;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int REM_W      = ROOT_W + 2;
	localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);
	localparam int STAMP_W    = 62;
	localparam int SECS_W     = 32;
	localparam int ERR_W      = 25;
	localparam int CSUB_W     = REM_W;

	localparam logic [2:0] MUL_LAST = 3'd4;

	localparam logic [63:0] NS_PER_S = 64'd1000000000;
	// 2^31 seconds in ns; magnitudes at or above it saturate
	localparam logic [STAMP_W-1:0] DEN_TOP = STAMP_W'(NS_PER_S << (SECS_W - 1));

	// 1e9 = 2^9 * 5^9: shift out 2^9, then floor(m * SEC_RECIP / 2^73) = floor(m / 5^9)
	localparam int SEC_SHIFT = 9;
	localparam int HALF_W    = 26;
	localparam int QM_W      = 2 * HALF_W;
	localparam int RECIP_W   = 53;
	localparam int RHI_W     = RECIP_W - HALF_W;
	localparam int PROD_W    = HALF_W + RHI_W;
	localparam int ACC_W     = 56;
	localparam int RECIP_SH  = 21;
	localparam logic [RECIP_W-1:0] SEC_RECIP = 53'd4835703278458517;
	localparam logic [1:0] SEC_STEP_LAST = 2'd3;

	typedef struct packed {
		logic                         lookup_ok;
		logic signed [COORD_BITS-1:0] ref_x;
		logic signed [COORD_BITS-1:0] ref_y;
		logic signed [COORD_BITS-1:0] est_x;
		logic signed [COORD_BITS-1:0] est_y;
		logic [STAMP_W-1:0]           stamp_ns;
	} sample_t;

	typedef struct packed {
		logic [ERR_W-1:0]         position_error;
		logic [PATH_BITS-1:0]     path_length;
		logic signed [SECS_W-1:0] seconds_since_start;
		logic [STAMP_W-1:0]       stamp_out;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ROOT_E,
		ST_ROOT_P,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} root_rsp_t;

	typedef struct packed {
		logic                     done;
		logic signed [SECS_W-1:0] secs;
	} div_rsp_t;

endpackage

[src/pose_error_and_path_length_tracker_core.sv]
// Pose error and path length tracker, top level with the item sequencer.
// Depends on pet_pkg, pet_isqrt, pet_secdiv.
//
// Each item with lookup_ok set yields one result: the floor distance from
// reference to estimate, the saturating path length of the reference track,
// whole seconds since the first valid stamp (int32 saturating) and the stamp.
// An item with lookup_ok clear is taken and dropped. A valid item keeps
// sample_stall high through the squaring on one 25x25 multiplier, the two runs
// of the shared root unit at one root bit per cycle and the load of the output
// register; no new item is taken before it is through. The seconds unit (a
// reciprocal multiply) starts when the item is taken and runs alongside
// the squaring. sample_stall stays high while
// an item is being worked on; the output register lets the next item enter
// while a result still waits to be taken, and a finished item waits in the
// last state while the previous result is still stalled.
module pose_error_and_path_length_tracker_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  pet_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output pet_pkg::result_t result
);
	import pet_pkg::*;

	state_t                       state_q;
	state_t                       state_d;
	logic                         started_q;
	logic                         first_q;
	logic signed [COORD_BITS-1:0] prev_x_q;
	logic signed [COORD_BITS-1:0] prev_y_q;
	logic [PATH_BITS-1:0]         path_q;
	logic [STAMP_W-1:0]           start_q;
	logic [STAMP_W-1:0]           stamp_q;
	logic [MAG_W-1:0]             mag_q [4];
	logic [2:0]                   mcnt_q;
	logic [SQ_W-1:0]              prod_q;
	logic [SQ_W-1:0]              sum_e_q;
	logic [SQ_W-1:0]              sum_p_q;
	logic [ROOT_W-1:0]            err_q;
	logic                         secs_rdy_q;
	logic                         result_valid_q;
	result_t                      result_q;

	logic                         accept;
	logic                         cap;
	logic                         sq_start;
	logic [SQ_W-1:0]              sq_rad;
	logic                         out_load;
	logic [MAG_W-1:0]             mag_sel;
	logic [SQ_W-1:0]              sq;
	logic [PATH_BITS:0]           psum;
	logic [STAMP_W-1:0]           eff_start;
	logic                         s_neg;
	logic [STAMP_W-1:0]           s_mag;
	root_rsp_t                    sq_rsp;
	div_rsp_t                     div_rsp;

	function automatic logic [MAG_W-1:0] absdiff(input logic signed [COORD_BITS-1:0] a,
			input logic signed [COORD_BITS-1:0] b);
		logic [MAG_W-1:0] d;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		return d[MAG_W-1] ? (~d + 1'b1) : d;
	endfunction

	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign cap          = accept && sample.lookup_ok;

	assign eff_start = started_q ? start_q : sample.stamp_ns;
	assign s_neg     = sample.stamp_ns < eff_start;
	assign s_mag     = s_neg ? (eff_start - sample.stamp_ns) : (sample.stamp_ns - eff_start);

	assign mag_sel = mag_q[mcnt_q[1:0]];
	assign sq      = SQ_W'(mag_sel) * SQ_W'(mag_sel);
	assign psum    = {1'b0, path_q} + (PATH_BITS + 1)'(sq_rsp.root);

	pet_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.rsp      (sq_rsp)
	);

	pet_secdiv u_secdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cap),
		.mag    (s_mag),
		.neg    (s_neg),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		sq_start = 1'b0;
		sq_rad   = sum_e_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cap)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mcnt_q == MUL_LAST) begin
					sq_start = 1'b1;
					state_d  = ST_ROOT_E;
				end
			end
			ST_ROOT_E: begin
				if (sq_rsp.done) begin
					sq_start = 1'b1;
					sq_rad   = sum_p_q;
					state_d  = ST_ROOT_P;
				end
			end
			ST_ROOT_P: begin
				if (sq_rsp.done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (secs_rdy_q && (!result_valid_q || !result_stall)) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q      <= 1'b0;
			first_q        <= 1'b0;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			path_q         <= '0;
			start_q        <= '0;
			mcnt_q         <= '0;
			secs_rdy_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cap) begin
				started_q  <= 1'b1;
				first_q    <= !started_q;
				prev_x_q   <= sample.ref_x;
				prev_y_q   <= sample.ref_y;
				mcnt_q     <= '0;
				secs_rdy_q <= 1'b0;
				if (!started_q)
					start_q <= sample.stamp_ns;
			end else if (state_q == ST_MUL) begin
				mcnt_q <= mcnt_q + 1'b1;
			end
			if (div_rsp.done)
				secs_rdy_q <= 1'b1;
			if ((state_q == ST_ROOT_P) && sq_rsp.done && !first_q)
				path_q <= psum[PATH_BITS] ? '1 : psum[PATH_BITS-1:0];
			if (out_load)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			mag_q[0] <= absdiff(sample.ref_x, sample.est_x);
			mag_q[1] <= absdiff(sample.ref_y, sample.est_y);
			mag_q[2] <= absdiff(sample.ref_x, prev_x_q);
			mag_q[3] <= absdiff(sample.ref_y, prev_y_q);
			stamp_q  <= sample.stamp_ns;
		end
		if (state_q == ST_MUL) begin
			if (mcnt_q < MUL_LAST)
				prod_q <= sq;
			case (mcnt_q)
				3'd1:    sum_e_q <= prod_q;
				3'd2:    sum_e_q <= sum_e_q + prod_q;
				3'd3:    sum_p_q <= prod_q;
				3'd4:    sum_p_q <= sum_p_q + prod_q;
				default: ;
			endcase
		end
		if ((state_q == ST_ROOT_E) && sq_rsp.done)
			err_q <= sq_rsp.root;
		if (out_load) begin
			result_q.position_error      <= ERR_W'(err_q);
			result_q.path_length         <= path_q;
			result_q.seconds_since_start <= div_rsp.secs;
			result_q.stamp_out           <= stamp_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[src/pet_csub.sv]
// Compare-and-subtract unit: a >= b flag and a - b.
// Used by the root unit. Depends on pet_pkg.
module pet_csub (
	input  logic [pet_pkg::CSUB_W-1:0] a,
	input  logic [pet_pkg::CSUB_W-1:0] b,
	output logic                       ge,
	output logic [pet_pkg::CSUB_W-1:0] diff
);
	import pet_pkg::*;

	logic [CSUB_W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign ge   = ~full[CSUB_W];
	assign diff = full[CSUB_W-1:0];

endmodule

[src/pet_isqrt.sv]
// Iterative floor square root, one root bit per cycle.
// Depends on pet_pkg and pet_csub.
module pet_isqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [pet_pkg::SQ_W-1:0] radicand,
	output pet_pkg::root_rsp_t       rsp
);
	import pet_pkg::*;

	logic [SQ_W-1:0]       rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [ROOT_CNT_W-1:0] cnt_q;
	logic                  active_q;
	logic                  done_q;
	logic [REM_W-1:0]      rem_sh;
	logic [REM_W-1:0]      trial;
	logic                  ge;
	logic [CSUB_W-1:0]     diff;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	pet_csub u_csub (
		.a    (CSUB_W'(rem_sh)),
		.b    (CSUB_W'(trial)),
		.ge   (ge),
		.diff (diff)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= active_q && (cnt_q == ROOT_CNT_W'(1));
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= ROOT_CNT_W'(ROOT_W);
			end else if (active_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ROOT_CNT_W'(1))
					active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (active_q) begin
			rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

[src/pet_secdiv.sv]
// Whole seconds from a nanosecond magnitude with int32 saturation: drops the 2^9
// factor of 1e9, then multiplies by a reciprocal of 5^9 in four partial products,
// one per cycle. Depends on pet_pkg.
module pet_secdiv (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pet_pkg::STAMP_W-1:0] mag,
	input  logic                        neg,
	output pet_pkg::div_rsp_t           rsp
);
	import pet_pkg::*;

	logic [QM_W-1:0]   m_q;
	logic              sat_q;
	logic              neg_q;
	logic [ACC_W-1:0]  acc_q;
	logic [1:0]        step_q;
	logic              active_q;
	logic              done_q;
	logic [HALF_W-1:0] op_a;
	logic [RHI_W-1:0]  op_b;
	logic [PROD_W-1:0] prod;
	logic [SECS_W-1:0] quo;

	// step bit 1 picks the dividend half, bit 0 the reciprocal half
	assign op_a = step_q[1] ? m_q[QM_W-1:HALF_W] : m_q[HALF_W-1:0];
	assign op_b = step_q[0] ? SEC_RECIP[RECIP_W-1:HALF_W] : RHI_W'(SEC_RECIP[HALF_W-1:0]);
	assign prod = PROD_W'(op_a) * PROD_W'(op_b);
	assign quo  = acc_q[RECIP_SH +: SECS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= active_q && (step_q == SEC_STEP_LAST);
			if (start) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (active_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SEC_STEP_LAST)
					active_q <= 1'b0;
			end
		end
	end

	// low partial products are folded down by 2^26 before the next weight is added
	always_ff @(posedge clk) begin
		if (start) begin
			m_q   <= mag[SEC_SHIFT +: QM_W];
			sat_q <= (mag >= DEN_TOP);
			neg_q <= neg;
		end else if (active_q) begin
			case (step_q)
				2'd0:          acc_q <= ACC_W'(prod[PROD_W-1:HALF_W]);
				SEC_STEP_LAST: acc_q <= ACC_W'(acc_q[ACC_W-1:HALF_W]) + ACC_W'(prod);
				default:       acc_q <= acc_q + ACC_W'(prod);
			endcase
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (sat_q)
			rsp.secs = neg_q ? {1'b1, {(SECS_W-1){1'b0}}} : {1'b0, {(SECS_W-1){1'b1}}};
		else
			rsp.secs = neg_q ? (~quo + 1'b1) : quo;
	end

endmodule

[src/pet_chk.sv]
// Port-level checks for the tracker core and the bind that attaches them.
// Depends on pet_pkg and pose_error_and_path_length_tracker_core.
module pet_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_valid,
	input logic             sample_stall,
	input pet_pkg::sample_t sample,
	input logic             result_valid,
	input logic             result_stall,
	input pet_pkg::result_t result
);
	import pet_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	a_busy_after_valid: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && sample.lookup_ok |=> sample_stall)
		else $error("not busy after a valid item");

	a_skip_free: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && !sample.lookup_ok |=> !sample_stall)
		else $error("skipped item made the block busy");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_stall))
		else $error("result appeared without an item in work");

endmodule

bind pose_error_and_path_length_tracker_core pet_chk u_pet_chk (.*);

[test/tb.sv]
`timescale 1ns / 100ps
// Testbench for pose_error_and_path_length_tracker_core: a tracker model predicts
// position error, path length, seconds since start and stamp for each valid item.
// Depends on pet_pkg and the core RTL.
module tb;
	import pet_pkg::*;

	localparam logic [63:0] START_NS = 64'h2000_0000_0000_0000;
	localparam logic [63:0] SAT_SPAN = 64'd2147483648 * 64'd1000000000;
	localparam logic [COORD_BITS-1:0] COORD_TOP = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] COORD_BOTTOM = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	sample_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	pose_error_and_path_length_tracker_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #6 clk = ~clk;

	// tracker state
	logic trk_started = 1'b0;
	logic signed [COORD_BITS-1:0] trk_prev_x = '0;
	logic signed [COORD_BITS-1:0] trk_prev_y = '0;
	logic [PATH_BITS-1:0] trk_path = '0;
	logic [63:0] trk_start = '0;

	result_t pending_results[$];
	result_t want;
	int unsigned field_errors = 0;

	bit tx_jitter = 1'b1;
	bit rx_jitter = 1'b1;
	int unsigned hold_req = 0;
	int unsigned rx_busy_left = 0;
	int unsigned quiet_cycles = 0;

	logic [COORD_BITS-1:0] stim_ref_x = '0;
	logic [COORD_BITS-1:0] stim_ref_y = '0;
	logic [63:0] wall_ns = START_NS;

	function automatic logic [63:0] floor_root(logic [63:0] v);
		logic [63:0] res, one, rem;
		res = '0;
		rem = v;
		one = 64'h4000_0000_0000_0000;
		while (one > rem)
			one >>= 2;
		while (one != 0) begin
			if (rem >= res + one) begin
				rem -= res + one;
				res = (res >> 1) + one;
			end else begin
				res >>= 1;
			end
			one >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] span_floor(longint dx, longint dy);
		return floor_root(64'(dx * dx) + 64'(dy * dy));
	endfunction

	function automatic result_t track_sample(sample_t s);
		result_t r;
		logic [63:0] stamp, sum, lag;
		stamp = 64'(s.stamp_ns);
		if (!trk_started)
			trk_start = stamp;
		r.position_error = ERR_W'(span_floor(
			longint'($signed(s.ref_x)) - longint'($signed(s.est_x)),
			longint'($signed(s.ref_y)) - longint'($signed(s.est_y))));
		if (trk_started) begin
			sum = 64'(trk_path) + span_floor(
				longint'($signed(s.ref_x)) - longint'(trk_prev_x),
				longint'($signed(s.ref_y)) - longint'(trk_prev_y));
			trk_path = (sum > 64'({PATH_BITS{1'b1}})) ? '1 : PATH_BITS'(sum);
		end
		trk_prev_x = s.ref_x;
		trk_prev_y = s.ref_y;
		trk_started = 1'b1;
		if (stamp >= trk_start) begin
			lag = (stamp - trk_start) / NS_PER_S;
			r.seconds_since_start = (lag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : SECS_W'(lag);
		end else begin
			lag = (trk_start - stamp) / NS_PER_S;
			if (lag > 64'h8000_0000)
				lag = 64'h8000_0000;
			r.seconds_since_start = SECS_W'(64'd0 - lag);
		end
		r.path_length = trk_path;
		r.stamp_out = s.stamp_ns;
		return r;
	endfunction

	function automatic sample_t pack_sample(logic ok, logic [COORD_BITS-1:0] rx,
			logic [COORD_BITS-1:0] ry, logic [COORD_BITS-1:0] ex,
			logic [COORD_BITS-1:0] ey, logic [63:0] stamp);
		sample_t s;
		s.lookup_ok = ok;
		s.ref_x = rx;
		s.ref_y = ry;
		s.est_x = ex;
		s.est_y = ey;
		s.stamp_ns = STAMP_W'(stamp);
		return s;
	endfunction

	function automatic logic [COORD_BITS-1:0] pick_coord(logic [COORD_BITS-1:0] near);
		case ($urandom_range(0, 9))
			0: return COORD_TOP;
			1: return COORD_BOTTOM;
			2: return '0;
			3, 4, 5: return near + COORD_BITS'($urandom_range(0, 4095)) - COORD_BITS'(2048);
			default: return COORD_BITS'($urandom());
		endcase
	endfunction

	function automatic logic [63:0] pick_stamp();
		case ($urandom_range(0, 9))
			0: return {$urandom(), $urandom()};
			1: return START_NS - 64'($urandom()) * 64'd1000;
			2: return START_NS + SAT_SPAN - 64'd3000000000 + 64'($urandom_range(0, 2000000000)) * 3;
			3: return START_NS - SAT_SPAN - 64'd3000000000 + 64'($urandom_range(0, 2000000000)) * 3;
			default: begin
				wall_ns += 64'($urandom_range(1, 200000000));
				return wall_ns;
			end
		endcase
	endfunction

	function automatic sample_t random_sample(logic ok);
		sample_t s;
		s = pack_sample(ok, pick_coord(stim_ref_x), pick_coord(stim_ref_y), '0, '0, pick_stamp());
		s.est_x = pick_coord(s.ref_x);
		s.est_y = pick_coord(s.ref_y);
		if (ok) begin
			stim_ref_x = s.ref_x;
			stim_ref_y = s.ref_y;
		end
		return s;
	endfunction

	task automatic send_sample(input sample_t s);
		int unsigned gap;
		if (tx_jitter && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample <= s;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
		if (s.lookup_ok)
			pending_results.push_back(track_sample(s));
	endtask

	task automatic drain_outputs();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic test_directed();
		send_sample(pack_sample(1'b0, COORD_TOP, COORD_BOTTOM, COORD_BOTTOM, COORD_TOP, 64'd0));
		send_sample(pack_sample(1'b1, COORD_TOP, COORD_TOP, COORD_BOTTOM, COORD_BOTTOM, START_NS));
		send_sample(pack_sample(1'b0, '0, '0, COORD_TOP, COORD_TOP, START_NS + 5 * NS_PER_S));
		send_sample(pack_sample(1'b1, COORD_BOTTOM, COORD_BOTTOM, COORD_TOP, COORD_TOP,
			START_NS + NS_PER_S));
		send_sample(pack_sample(1'b1, COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM,
			START_NS + NS_PER_S - 1));
		send_sample(pack_sample(1'b1, '0, '0, '1, '0, START_NS - 1));
		send_sample(pack_sample(1'b1, COORD_TOP, COORD_BOTTOM, COORD_BOTTOM, COORD_TOP,
			START_NS - NS_PER_S));
		send_sample(pack_sample(1'b1, COORD_BITS'(3), COORD_BITS'(4), '0, '0, START_NS - SAT_SPAN));
		send_sample(pack_sample(1'b1, '0, COORD_BOTTOM, '0, COORD_TOP,
			START_NS - SAT_SPAN - NS_PER_S));
		send_sample(pack_sample(1'b1, '1, '1, COORD_BITS'(1), COORD_BITS'(1), 64'd0));
		send_sample(pack_sample(1'b1, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP,
			START_NS + SAT_SPAN - NS_PER_S));
		send_sample(pack_sample(1'b1, COORD_BOTTOM, COORD_TOP, '0, '0, START_NS + SAT_SPAN));
		send_sample(pack_sample(1'b1, COORD_TOP, '0, COORD_BOTTOM, '1, (64'd1 << 62) - 1));
		send_sample(pack_sample(1'b1, COORD_BOTTOM, '0, COORD_TOP, '0,
			START_NS + SAT_SPAN + NS_PER_S));
		send_sample(pack_sample(1'b0, '1, COORD_TOP, '1, COORD_BOTTOM, (64'd1 << 62) - 1));
		send_sample(pack_sample(1'b1, '0, '0, '0, '0, START_NS));
		send_sample(pack_sample(1'b1, COORD_BITS'(1), '0, '0, '0, START_NS + NS_PER_S - 1));
		drain_outputs();
	endtask

	// receiver holds off long enough for the core to back up into its input
	task automatic test_receiver_hold();
		tx_jitter = 1'b0;
		hold_req = 300;
		repeat (16) send_sample(random_sample(1'b1));
		drain_outputs();
	endtask

	task automatic test_sender_pause();
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
		repeat (8) send_sample(random_sample($urandom_range(0, 3) != 0));
		drain_outputs();
		repeat (8) send_sample(random_sample($urandom_range(0, 3) != 0));
		drain_outputs();
	endtask

	task automatic test_random();
		int unsigned valid_sent;
		logic ok;
		for (int chunk = 0; chunk < 8; chunk++) begin
			tx_jitter = (chunk == 0) || (chunk != 3 && $urandom_range(0, 1) == 1);
			rx_jitter = (chunk == 0) || (chunk != 3 && $urandom_range(0, 1) == 1);
			valid_sent = 0;
			while (valid_sent < 200) begin
				ok = ($urandom_range(0, 7) != 0);
				send_sample(random_sample(ok));
				if (ok)
					valid_sent++;
			end
			if (chunk % 2 == 1)
				drain_outputs();
		end
	endtask

	// corner-to-corner hops, the longest steps the reference track can take
	task automatic test_corner_hops();
		bit corner;
		sample_t s;
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		corner = 1'b0;
		repeat (40) begin
			corner = !corner;
			s = random_sample(1'b1);
			s.ref_x = corner ? COORD_TOP : COORD_BOTTOM;
			s.ref_y = corner ? COORD_TOP : COORD_BOTTOM;
			if ($urandom_range(0, 15) == 0)
				send_sample(random_sample(1'b0));
			send_sample(s);
		end
	endtask

	always @(posedge clk) begin
		if (hold_req != 0) begin
			rx_busy_left = hold_req;
			hold_req = 0;
		end
		if (rx_busy_left != 0) begin
			rx_busy_left--;
			result_stall <= 1'b1;
		end else if (rx_jitter && $urandom_range(0, 5) == 0) begin
			rx_busy_left = $urandom_range(0, 2);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with none pending: position_error %0d path_length %0d",
					result.position_error, result.path_length);
				field_errors++;
			end else begin
				want = pending_results.pop_front();
				if (result.position_error !== want.position_error) begin
					$error("position_error: expected %0d, got %0d",
						want.position_error, result.position_error);
					field_errors++;
				end
				if (result.path_length !== want.path_length) begin
					$error("path_length: expected %0d, got %0d",
						want.path_length, result.path_length);
					field_errors++;
				end
				if (result.seconds_since_start !== want.seconds_since_start) begin
					$error("seconds_since_start: expected %0d, got %0d",
						$signed(want.seconds_since_start), $signed(result.seconds_since_start));
					field_errors++;
				end
				if (result.stamp_out !== want.stamp_out) begin
					$error("stamp_out: expected %0d, got %0d", want.stamp_out, result.stamp_out);
					field_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_receiver_hold();
		test_sender_pause();
		test_random();
		test_corner_hops();
		drain_outputs();
		repeat (100) @(posedge clk);
		if (pending_results.size() == 0 && field_errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

[files.f]
src/pet_pkg.sv
src/pet_csub.sv
src/pet_isqrt.sv
src/pet_secdiv.sv
src/pose_error_and_path_length_tracker_core.sv
src/pet_chk.sv
test/tb.sv
